/* rtl/imss_pkg.sv */
// Shared types and constants for the I2C master segment sequencer.
package imss_pkg;

    localparam int unsigned MAX_SEGMENTS = 4;
    localparam int unsigned MAX_LEN      = 16;
    localparam int unsigned SEG_SLOTS    = 4;
    localparam int unsigned STORE_DEPTH  = 64;

    typedef enum logic [1:0] {
        MODE_EVENT = 2'd0,
        MODE_LOAD  = 2'd1,
        MODE_START = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ACK_LEAVE = 2'd0,
        ACK_SET   = 2'd1,
        ACK_CLEAR = 2'd2
    } ack_t;

    typedef enum logic [2:0] {
        ST_PENDING  = 3'd0,
        ST_SUCCESS  = 3'd1,
        ST_NACK     = 3'd2,
        ST_ERROR    = 3'd3,
        ST_SPURIOUS = 3'd4
    } status_t;

    // Controller status codes
    localparam logic [7:0] SC_START         = 8'h08;
    localparam logic [7:0] SC_RSTART        = 8'h10;
    localparam logic [7:0] SC_MT_ADDR_ACK   = 8'h18;
    localparam logic [7:0] SC_MT_ADDR_NACK  = 8'h20;
    localparam logic [7:0] SC_MT_DATA_ACK   = 8'h28;
    localparam logic [7:0] SC_MT_DATA_NACK  = 8'h30;
    localparam logic [7:0] SC_MR_ADDR_ACK   = 8'h40;
    localparam logic [7:0] SC_MR_ADDR_NACK  = 8'h48;
    localparam logic [7:0] SC_MR_DATA_ACK   = 8'h50;
    localparam logic [7:0] SC_MR_DATA_NACK  = 8'h58;

    // APB register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_SEG_COUNT = 3'd0;
    localparam logic [2:0] REG_SEG0      = 3'd1;
    localparam logic [2:0] REG_SEG1      = 3'd2;
    localparam logic [2:0] REG_SEG2      = 3'd3;
    localparam logic [2:0] REG_SEG3      = 3'd4;

    // Result item, clear_start in the lowest bit
    typedef struct packed {
        status_t    transfer_status;
        logic [3:0] rx_index;
        logic [1:0] rx_segment;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic [7:0] data_out;
        logic       data_write;
        logic       clear_all;
        ack_t       ack_action;
        logic       set_stop;
        logic       set_start;
        logic       clear_start;
    } result_t;

endpackage

/* rtl/i2c_master_segment_sequencer_top.sv */
// I2C master segment sequencer: event decoder, transmit store and output skid buffer.
//
// Input stream s_*: one transaction per controller event (s_tuser = 0), transmit
// byte load (s_tuser = 1) or transfer start (s_tuser = 2). Every input transaction
// produces exactly one result transaction on m_*, carrying the control actions,
// any received byte with its segment and position, and the transfer status.
// The APB port holds the segment count and four segment descriptors; write it
// only while no transaction is in flight.
// The decision is made in the accept cycle and the result is registered in the
// output register, or in the skid register while m_* is held. Throughput is one
// transaction per cycle while s_tready is high; the sequencing state and the
// transmit store prefetch update in the accept cycle, so the next event sees them.
// The transmit store (64 bytes) has one write port and one registered read port;
// the read is prefetched at the address the next event will use, with a bypass
// for a load to that same address.
// Reset clears the sequencing state to idle/pending and the result buffer; the
// store contents are undefined until loaded.
// When m_tready is low, one more transaction is taken into a skid register, then
// s_tready drops until the receiver drains it.
module i2c_master_segment_sequencer_top (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // status_code[7:0], si_flag[8], rx_data[16:9], load_segment[18:17],
    // load_index[22:19], load_byte[30:23], zero[31]
    input  logic [31:0] s_tdata,
    // mode[1:0]
    input  logic [1:0]  s_tuser,
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // clear_start[0], set_start[1], set_stop[2], ack_action[4:3], clear_all[5],
    // data_write[6], data_out[14:7], rx_valid[15], rx_byte[23:16],
    // rx_segment[25:24], rx_index[29:26], transfer_status[32:30], zero[39:33]
    output logic [39:0] m_tdata
);

    // configuration
    logic [2:0]  seg_count_reg;
    logic [15:0] seg_desc_reg [imss_pkg::SEG_SLOTS];

    // sequencing state
    logic [1:0]        cur_seg_reg, cur_seg_next;
    logic [4:0]        byte_pos_reg, byte_pos_next;
    logic [2:0]        seg_left_reg, seg_left_next;
    imss_pkg::status_t status_reg, status_next;

    // transmit store and prefetch
    logic [7:0] store_mem [imss_pkg::STORE_DEPTH];
    logic [7:0] rd_data_reg;
    logic       byp_reg;
    logic [7:0] byp_data_reg;
    logic [5:0] wr_addr;
    logic [5:0] rd_addr;
    logic       wr_en;
    logic [7:0] tx_byte;

    // result buffer
    imss_pkg::result_t out_reg, skid_reg, res;
    logic              out_valid_reg, skid_valid_reg;

    // input fields
    imss_pkg::mode_t mode;
    logic [7:0]      status_code;
    logic            si_flag;
    logic [7:0]      rx_data;
    logic [1:0]      load_segment;
    logic [3:0]      load_index;
    logic [7:0]      load_byte;

    logic        push;
    logic        pop;
    logic        cfg_wr;
    logic [15:0] desc;
    logic [7:0]  seg_len;
    logic [4:0]  bp_inc;
    logic        finish;
    logic [2:0]  seg_start;

    assign mode         = imss_pkg::mode_t'(s_tuser);
    assign status_code  = s_tdata[7:0];
    assign si_flag      = s_tdata[8];
    assign rx_data      = s_tdata[16:9];
    assign load_segment = s_tdata[18:17];
    assign load_index   = s_tdata[22:19];
    assign load_byte    = s_tdata[30:23];

    assign push = s_tvalid && s_tready;
    assign pop  = m_tvalid && m_tready;

    // ---------------- APB ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_count_reg <= 3'd1;
            for (int i = 0; i < imss_pkg::SEG_SLOTS; i++) begin
                seg_desc_reg[i] <= 16'd0;
            end
        end else if (cfg_wr) begin
            priority case (paddr[4:2])
                imss_pkg::REG_SEG_COUNT: seg_count_reg   <= pwdata[2:0];
                imss_pkg::REG_SEG0:      seg_desc_reg[0] <= pwdata[15:0];
                imss_pkg::REG_SEG1:      seg_desc_reg[1] <= pwdata[15:0];
                imss_pkg::REG_SEG2:      seg_desc_reg[2] <= pwdata[15:0];
                imss_pkg::REG_SEG3:      seg_desc_reg[3] <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            imss_pkg::REG_SEG_COUNT: prdata = {29'd0, seg_count_reg};
            imss_pkg::REG_SEG0:      prdata = {16'd0, seg_desc_reg[0]};
            imss_pkg::REG_SEG1:      prdata = {16'd0, seg_desc_reg[1]};
            imss_pkg::REG_SEG2:      prdata = {16'd0, seg_desc_reg[2]};
            imss_pkg::REG_SEG3:      prdata = {16'd0, seg_desc_reg[3]};
            default:                 prdata = 32'd0;
        endcase
    end

    // ---------------- decision logic ----------------
    assign desc    = seg_desc_reg[cur_seg_reg];
    assign seg_len = (desc[15:8] > 8'(imss_pkg::MAX_LEN)) ? 8'(imss_pkg::MAX_LEN) : desc[15:8];
    assign bp_inc  = (byte_pos_reg != 5'd31) ? byte_pos_reg + 5'd1 : byte_pos_reg;
    assign tx_byte = byp_reg ? byp_data_reg : rd_data_reg;

    always_comb begin
        if (int'(seg_count_reg) > imss_pkg::MAX_SEGMENTS) begin
            seg_start = 3'(imss_pkg::MAX_SEGMENTS);
        end else begin
            seg_start = seg_count_reg;
        end
        if (int'(seg_start) > imss_pkg::SEG_SLOTS) begin
            seg_start = 3'(imss_pkg::SEG_SLOTS);
        end
        if (seg_start == 3'd0) begin
            seg_start = 3'd1;
        end
    end

    always_comb begin
        res           = '0;
        cur_seg_next  = cur_seg_reg;
        byte_pos_next = byte_pos_reg;
        seg_left_next = seg_left_reg;
        status_next   = status_reg;
        finish        = 1'b0;

        if (push) begin
            unique case (mode)
                imss_pkg::MODE_LOAD: ;
                imss_pkg::MODE_START: begin
                    seg_left_next = seg_start;
                    cur_seg_next  = 2'd0;
                    byte_pos_next = 5'd0;
                    status_next   = imss_pkg::ST_PENDING;
                    res.clear_all = 1'b1;
                    res.set_start = 1'b1;
                end
                imss_pkg::MODE_EVENT: begin
                    if (!si_flag) begin
                        status_next = imss_pkg::ST_SPURIOUS;
                    end else begin
                        unique case (status_code)
                            imss_pkg::SC_START, imss_pkg::SC_RSTART: begin
                                res.clear_start = 1'b1;
                                res.data_write  = 1'b1;
                                res.data_out    = {desc[6:0], desc[7]};
                            end
                            imss_pkg::SC_MT_ADDR_NACK, imss_pkg::SC_MR_ADDR_NACK,
                            imss_pkg::SC_MT_DATA_NACK: begin
                                res.set_stop = 1'b1;
                                status_next  = imss_pkg::ST_NACK;
                            end
                            imss_pkg::SC_MT_ADDR_ACK, imss_pkg::SC_MT_DATA_ACK: begin
                                if ({3'd0, byte_pos_reg} < seg_len) begin
                                    res.data_write = 1'b1;
                                    res.data_out   = tx_byte;
                                    byte_pos_next  = bp_inc;
                                end else begin
                                    finish = 1'b1;
                                end
                            end
                            imss_pkg::SC_MR_ADDR_ACK: begin
                                res.ack_action = ({3'd0, byte_pos_reg} + 8'd1 == seg_len) ?
                                                 imss_pkg::ACK_CLEAR : imss_pkg::ACK_SET;
                            end
                            imss_pkg::SC_MR_DATA_ACK: begin
                                res.rx_valid   = 1'b1;
                                res.rx_byte    = rx_data;
                                res.rx_segment = cur_seg_reg;
                                res.rx_index   = byte_pos_reg[3:0];
                                byte_pos_next  = bp_inc;
                                // ack decision looks at the position after this byte
                                res.ack_action = ({3'd0, bp_inc} + 8'd1 == seg_len) ?
                                                 imss_pkg::ACK_CLEAR : imss_pkg::ACK_SET;
                            end
                            imss_pkg::SC_MR_DATA_NACK: begin
                                res.rx_valid   = 1'b1;
                                res.rx_byte    = rx_data;
                                res.rx_segment = cur_seg_reg;
                                res.rx_index   = byte_pos_reg[3:0];
                                byte_pos_next  = bp_inc;
                                finish         = 1'b1;
                            end
                            default: begin
                                // bus error, arbitration lost and anything unknown
                                res.clear_all = 1'b1;
                                status_next   = imss_pkg::ST_ERROR;
                            end
                        endcase
                    end
                end
                default: ;
            endcase

            if (finish) begin
                if (seg_left_reg <= 3'd1) begin
                    seg_left_next = 3'd0;
                    res.set_stop  = 1'b1;
                    status_next   = imss_pkg::ST_SUCCESS;
                end else begin
                    seg_left_next = seg_left_reg - 3'd1;
                    cur_seg_next  = cur_seg_reg + 2'd1;
                    byte_pos_next = 5'd0;
                    res.set_start = 1'b1;
                end
            end
        end

        res.transfer_status = status_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_seg_reg  <= 2'd0;
            byte_pos_reg <= 5'd0;
            seg_left_reg <= 3'd0;
            status_reg   <= imss_pkg::ST_PENDING;
        end else begin
            cur_seg_reg  <= cur_seg_next;
            byte_pos_reg <= byte_pos_next;
            seg_left_reg <= seg_left_next;
            status_reg   <= status_next;
        end
    end

    // ---------------- transmit store ----------------
    assign wr_en   = push && (mode == imss_pkg::MODE_LOAD);
    assign wr_addr = {load_segment, load_index};
    assign rd_addr = {cur_seg_next, byte_pos_next[3:0]};

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= load_byte;
        end
    end

    // prefetch the byte the next event would send; bypass a same-cycle load
    always_ff @(posedge aclk) begin
        rd_data_reg  <= store_mem[rd_addr];
        byp_data_reg <= load_byte;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_reg <= 1'b0;
        end else begin
            byp_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    // ---------------- result buffer ----------------
    assign s_tready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (out_valid_reg && !pop) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_reg <= skid_reg;
            end
        end else if (push) begin
            if (out_valid_reg && !pop) begin
                skid_reg <= res;
            end else begin
                out_reg <= res;
            end
        end
    end

endmodule
